/* sv/ufn_pkg.sv */
// Shared types, character codes and sizing constants for the text normalizer.
package ufn_pkg;

  // Default depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // UTF-8 lead bytes that start a two-byte accented letter
  localparam logic [7:0] LEAD_C3_BYTE = 8'hC3;
  localparam logic [7:0] LEAD_C5_BYTE = 8'hC5;

  // ASCII codes
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_Z = 8'd122;
  localparam logic [7:0] CH_DIGIT_0 = 8'd48;
  localparam logic [7:0] CH_DIGIT_9 = 8'd57;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  // Base letters produced by the accent table
  localparam logic [7:0] CH_A = 8'd97;
  localparam logic [7:0] CH_C = 8'd99;
  localparam logic [7:0] CH_E = 8'd101;
  localparam logic [7:0] CH_I = 8'd105;
  localparam logic [7:0] CH_O = 8'd111;
  localparam logic [7:0] CH_U = 8'd117;
  localparam logic [7:0] CH_Y = 8'd121;

  // Pending lead byte, one-hot
  typedef enum logic [2:0] {
    LEAD_NONE = 3'b001,
    LEAD_C3   = 3'b010,
    LEAD_C5   = 3'b100
  } lead_e;

  // One classified item: one or two output characters
  typedef struct packed {
    logic [7:0] ch_a;
    logic [7:0] ch_b;
    logic       two;
    logic       wend;
  } entry_t;

endpackage

/* sv/utf8_french_text_normalizer.sv */
// Top level of the UTF-8 French text normalizer.
//
// Input channel: in_valid_i / in_stall_o carry one UTF-8 byte per item
// (in_octet_i) with word_end_in_i on the last byte of a word. Output
// channel: out_valid_o / out_stall_i carry one ASCII character per item
// with run_last_o and word_end_out_o. cfg_we_i writes keep_digits.
// Throughput: one input byte per cycle while the queue is not full. A lead
// byte 0xC3/0xC5 gives no output unless it ends a word, when it gives a space;
// the pairs 0xC3 0xA6 and 0xC5 0x93 give two characters. The back end holds
// the second character in its own register while the queue fills; once the
// queue is full the input stalls. An accepted byte is written to the queue and
// then loaded into the output register. in_stall_o rises only when the queue
// (QueueDepth items) is full. Reset clears keep_digits, the pending lead byte,
// the queue and the output valid flag. While out_stall_i is high the output
// item holds and the queue fills, after which the input is stalled.
module utf8_french_text_normalizer #(
  parameter int unsigned QueueDepth = ufn_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_octet_i,
  input  logic       word_end_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_octet_o,
  output logic       run_last_o,
  output logic       word_end_out_o
);

  logic            q_push, q_full, q_pop, q_valid;
  ufn_pkg::entry_t q_wr_entry, q_rd_entry;

  // Classification
  ufn_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_octet_i    (in_octet_i),
    .word_end_in_i (word_end_in_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (q_wr_entry)
  );

  // Decoupling queue
  ufn_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_rd_entry)
  );

  // Character emission
  ufn_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_entry_i      (q_rd_entry),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_octet_o    (out_octet_o),
    .run_last_o     (run_last_o),
    .word_end_out_o (word_end_out_o)
  );

endmodule

/* sv/ufn_front.sv */
// Front end: accepts input bytes, tracks the pending lead byte, classifies items.
module ufn_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      in_octet_i,
  input  logic            word_end_in_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output ufn_pkg::entry_t q_entry_o
);

  // Second byte after 0xC3
  function automatic ufn_pkg::entry_t map_c3(input logic [7:0] b, input logic w);
    ufn_pkg::entry_t e;
    e.ch_a = ufn_pkg::CH_SPACE;
    e.ch_b = ufn_pkg::CH_SPACE;
    e.two  = 1'b0;
    e.wend = w;
    case (b) inside
      8'd169, 8'd137, 8'd168, 8'd136, 8'd170, 8'd138, 8'd171, 8'd139:
        e.ch_a = ufn_pkg::CH_E;
      8'd160, 8'd129, 8'd128, 8'd162, 8'd130, 8'd164, 8'd132:
        e.ch_a = ufn_pkg::CH_A;
      8'd174, 8'd142, 8'd175, 8'd143:
        e.ch_a = ufn_pkg::CH_I;
      8'd167, 8'd135:
        e.ch_a = ufn_pkg::CH_C;
      8'd180, 8'd148, 8'd182, 8'd150:
        e.ch_a = ufn_pkg::CH_O;
      8'd187, 8'd155, 8'd185, 8'd153, 8'd188, 8'd156:
        e.ch_a = ufn_pkg::CH_U;
      8'd191:
        e.ch_a = ufn_pkg::CH_Y;
      8'd166: begin
        e.ch_a = ufn_pkg::CH_A;
        e.ch_b = ufn_pkg::CH_E;
        e.two  = 1'b1;
      end
      default: e.ch_a = ufn_pkg::CH_SPACE;
    endcase
    return e;
  endfunction

  // Second byte after 0xC5
  function automatic ufn_pkg::entry_t map_c5(input logic [7:0] b, input logic w);
    ufn_pkg::entry_t e;
    e.ch_a = ufn_pkg::CH_SPACE;
    e.ch_b = ufn_pkg::CH_SPACE;
    e.two  = 1'b0;
    e.wend = w;
    case (b)
      8'd147: begin
        e.ch_a = ufn_pkg::CH_O;
        e.ch_b = ufn_pkg::CH_E;
        e.two  = 1'b1;
      end
      8'd184:  e.ch_a = ufn_pkg::CH_Y;
      default: e.ch_a = ufn_pkg::CH_SPACE;
    endcase
    return e;
  endfunction

  logic            keep_digits_q;
  ufn_pkg::lead_e  lead_q, lead_d;
  logic            accept;
  logic            push_c;
  ufn_pkg::entry_t entry_c;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_digits_q <= 1'b0;
    end else if (cfg_we_i) begin
      keep_digits_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Classification of the incoming byte
  always_comb begin
    lead_d       = ufn_pkg::LEAD_NONE;
    push_c       = 1'b1;
    entry_c.ch_a = ufn_pkg::CH_SPACE;
    entry_c.ch_b = ufn_pkg::CH_SPACE;
    entry_c.two  = 1'b0;
    entry_c.wend = word_end_in_i;
    case (lead_q)
      ufn_pkg::LEAD_C3: entry_c = map_c3(in_octet_i, word_end_in_i);
      ufn_pkg::LEAD_C5: entry_c = map_c5(in_octet_i, word_end_in_i);
      default: begin
        if (in_octet_i == ufn_pkg::LEAD_C3_BYTE || in_octet_i == ufn_pkg::LEAD_C5_BYTE) begin
          // a lead at word end collapses to a space; otherwise hold it
          if (!word_end_in_i) begin
            push_c = 1'b0;
            lead_d = (in_octet_i == ufn_pkg::LEAD_C3_BYTE) ? ufn_pkg::LEAD_C3
                                                            : ufn_pkg::LEAD_C5;
          end
        end else if (in_octet_i inside {[ufn_pkg::CH_UPPER_A:ufn_pkg::CH_UPPER_Z]}) begin
          entry_c.ch_a = in_octet_i + ufn_pkg::CASE_OFFSET;
        end else if (in_octet_i inside {[ufn_pkg::CH_LOWER_A:ufn_pkg::CH_LOWER_Z]}) begin
          entry_c.ch_a = in_octet_i;
        end else if (in_octet_i inside {[ufn_pkg::CH_DIGIT_0:ufn_pkg::CH_DIGIT_9]}) begin
          entry_c.ch_a = keep_digits_q ? in_octet_i : ufn_pkg::CH_SPACE;
        end
      end
    endcase
  end

  // Pending lead state advances on every accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= ufn_pkg::LEAD_NONE;
    end else if (accept) begin
      lead_q <= lead_d;
    end
  end

  assign q_push_o  = accept && push_c;
  assign q_entry_o = entry_c;

endmodule

/* sv/ufn_queue.sv */
// Small FIFO of classified items between the front and back ends.
module ufn_queue #(
  parameter int unsigned Depth = ufn_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ufn_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output ufn_pkg::entry_t entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ufn_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* sv/ufn_back.sv */
// Back end: expands queued items into one or two characters in an output register.
module ufn_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  ufn_pkg::entry_t q_entry_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_octet_o,
  output logic            run_last_o,
  output logic            word_end_out_o
);

  logic       out_valid_q;
  logic [7:0] out_octet_q;
  logic       run_last_q, word_end_q;
  logic       second_pend_q;
  logic [7:0] second_ch_q;
  logic       second_wend_q;
  logic       load;

  // Output register may take a new character when empty or being drained
  assign load    = !out_valid_q || !out_stall_i;
  assign q_pop_o = load && !second_pend_q && q_valid_i;

  // Control: output valid and pending second letter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      second_pend_q <= 1'b0;
    end else if (load) begin
      if (second_pend_q) begin
        out_valid_q   <= 1'b1;
        second_pend_q <= 1'b0;
      end else begin
        out_valid_q   <= q_valid_i;
        second_pend_q <= q_valid_i && q_entry_i.two;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (second_pend_q) begin
        out_octet_q <= second_ch_q;
        run_last_q  <= 1'b1;
        word_end_q  <= second_wend_q;
      end else if (q_valid_i) begin
        out_octet_q   <= q_entry_i.ch_a;
        run_last_q    <= !q_entry_i.two;
        word_end_q    <= q_entry_i.wend && !q_entry_i.two;
        second_ch_q   <= q_entry_i.ch_b;
        second_wend_q <= q_entry_i.wend;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_octet_o    = out_octet_q;
  assign run_last_o     = run_last_q;
  assign word_end_out_o = word_end_q;

endmodule

/* sv/ufn_checker.sv */
// Port-level checks on the normalizer output, bound to the top level.
module ufn_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_octet_o,
  input logic       run_last_o,
  input logic       word_end_out_o
);

  // Output register is empty while reset is held
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // A stalled output item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_octet_o)
      && $stable(run_last_o) && $stable(word_end_out_o))
    else $error("stalled output item changed");

  // Word end only on the final character of an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && word_end_out_o |-> run_last_o)
    else $error("word end without run_last");

  // First half of an expansion is always 'a' or 'o'
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |-> out_octet_o == ufn_pkg::CH_A
      || out_octet_o == ufn_pkg::CH_O)
    else $error("unexpected first letter of a two-letter expansion");

  // Output alphabet: lower-case letter, digit or space
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_octet_o == ufn_pkg::CH_SPACE
      || (out_octet_o >= ufn_pkg::CH_LOWER_A && out_octet_o <= ufn_pkg::CH_LOWER_Z)
      || (out_octet_o >= ufn_pkg::CH_DIGIT_0 && out_octet_o <= ufn_pkg::CH_DIGIT_9))
    else $error("output character outside the normalized set");

endmodule

bind utf8_french_text_normalizer ufn_checker u_ufn_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_octet_o    (out_octet_o),
  .run_last_o     (run_last_o),
  .word_end_out_o (word_end_out_o)
);
